/* design/apf_pkg.sv */
`default_nettype none

package apf_pkg;

    // Table depth and derived widths
    localparam int MAX_TAPS = 128;
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    // Field widths
    localparam int TAPCFG_W = 8;
    localparam int COEF_W   = 16;
    localparam int SMP_W    = 16;
    localparam int Y_W      = 32;
    localparam int LVL_W    = 24;
    localparam int PROD_W   = COEF_W + Y_W;

    // Accumulator in units of 2^-22: sample * 2^22 - sum(coef * delay)
    localparam int FRAC_SH  = 22;
    localparam int ACC_W    = 56;
    localparam int RND_SH   = 14;
    localparam int YW_W     = ACC_W - RND_SH;

    // Level: y / 2560, offset 400 * 2560 above the threshold
    localparam int THRESH      = 400 * 10 * 256;
    localparam int LVL_PRE_SH  = 9;
    localparam int LVL_N_W     = Y_W - LVL_PRE_SH;
    localparam int LVL_RCP_SH  = 25;
    localparam int LVL_RCP     = ((1 << LVL_RCP_SH) + 4) / 5;
    localparam int LVL_RCP_W   = 23;
    localparam int LVL_PROD_W  = LVL_N_W + LVL_RCP_W;
    localparam int LVL_Q_W     = LVL_PROD_W - LVL_RCP_SH;

    localparam int TAP_RESET = 100;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [6:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [SMP_W-1:0]  sample;
    } apf_req_t;

    typedef struct packed {
        logic                    is_sample;
        logic signed [Y_W-1:0]   filtered;
        logic signed [LVL_W-1:0] level;
        logic                    saturated;
    } apf_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_RND  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } apf_state_t;

endpackage

`default_nettype wire

/* design/allpole_pink_noise_filter.sv */
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     apf_req_t   (sample or coefficient write)
// rsp       out        rsp_valid / rsp_stall     apf_rsp_t   (filtered sample or write ack)
// cfg       in         cfg_we                    tap_count, 8 bits
//
// A sample shows rsp_valid after one multiply-accumulate per tap,
// taps = min(tap_count, 128), on one 16x32 multiplier,
// then rounding, level scaling and the result load; the next transfer can follow in the cycle
// after the result load. A coefficient write passes the finish step before its ack shows.
// Reset clears both tables through per-entry valid bits at once; tap_count resets to 100.
// req_stall is high while an item is in work; a new request is taken while a result waits.

module allpole_pink_noise_filter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire apf_pkg::apf_req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output apf_pkg::apf_rsp_t      rsp_data,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata
);

    import apf_pkg::*;

    apf_state_t state_reg, state_next;

    logic [TAPCFG_W-1:0] tap_count_reg;
    logic [CNT_W-1:0]    taps;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;

    // per-entry valid bits; an entry never written reads as zero
    logic [MAX_TAPS-1:0] coef_vld_reg;
    logic [MAX_TAPS-1:0] dly_vld_reg;

    // MAC pipeline: s1 = RAM data out, s2 = product registered
    logic              s1_vld_reg, s2_vld_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic              cv_q_reg, dv_q_reg;

    logic [COEF_W-1:0] coef_rdata;
    logic [Y_W-1:0]    dly_rdata;
    logic signed [COEF_W-1:0] coef_q;
    logic signed [Y_W-1:0]    dly_q;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic              issue;
    logic [CNT_W-1:0]  shift_dst;
    logic              shift_we;

    logic              coef_we;
    logic              dly_we;
    logic [ADDR_W-1:0] dly_waddr;
    logic [Y_W-1:0]    dly_wdata;

    // rounding and clipping
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [YW_W-1:0]  yw;
    logic                    y_clip;
    logic signed [Y_W-1:0]   y_sat;
    logic signed [Y_W-1:0]   y_reg;
    logic                    sat_reg;
    logic                    is_smp_reg;

    // level
    logic signed [Y_W:0]         lvl_v;
    logic                        lvl_neg;
    logic [Y_W:0]                lvl_mag;
    logic [LVL_N_W-1:0]          lvl_n;
    logic [LVL_PROD_W-1:0]       lvl_prod_reg;
    logic                        lvl_neg_reg;
    logic [LVL_Q_W-1:0]          lvl_q;
    logic signed [LVL_W-1:0]     level;

    logic     req_xfer;
    logic     rsp_xfer;
    logic     rsp_load;
    logic     rsp_valid_reg;
    apf_rsp_t rsp_reg;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;

    assign taps = (32'(tap_count_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_reg);

    assign issue   = (state_reg == ST_MAC) && (issue_cnt_reg < taps);
    assign coef_we = req_xfer && (req_data.req_type == REQ_COEF);

    // tables
    apf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (req_data.coef_index),
        .wdata (req_data.coef_value),
        .raddr (issue_cnt_reg[ADDR_W-1:0]),
        .rdata (coef_rdata)
    );

    apf_ram #(.WIDTH(Y_W), .DEPTH(MAX_TAPS)) u_dly_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (issue_cnt_reg[ADDR_W-1:0]),
        .rdata (dly_rdata)
    );

    assign coef_q = cv_q_reg ? $signed(coef_rdata) : '0;
    assign dly_q  = dv_q_reg ? $signed(dly_rdata) : '0;

    // delay[i] moves to delay[i+1] as it streams past, within the active taps
    assign shift_dst = CNT_W'(s1_idx_reg) + CNT_W'(1);
    assign shift_we  = (state_reg == ST_MAC) && s1_vld_reg && (shift_dst < taps);

    // newest output lands in delay[0] once the sum is done
    assign dly_we    = shift_we || (state_reg == ST_DIV);
    assign dly_waddr = (state_reg == ST_DIV) ? '0 : shift_dst[ADDR_W-1:0];
    assign dly_wdata = (state_reg == ST_DIV) ? y_reg : dly_q;

    // y = floor((acc + 2^13) / 2^14), clipped to 32 bits
    assign rnd_sum = acc_reg + ACC_W'(1 << (RND_SH - 1));
    assign yw      = rnd_sum[ACC_W-1:RND_SH];
    assign y_clip  = !((&yw[YW_W-1:Y_W-1]) || !(|yw[YW_W-1:Y_W-1]));
    assign y_sat   = y_clip ? (yw[YW_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}})
                            : yw[Y_W-1:0];

    // level = trunc(v / 2560) = sign * floor(floor(|v| / 512) / 5)
    assign lvl_v   = (y_reg < $signed(Y_W'(THRESH))) ? {y_reg[Y_W-1], y_reg}
                                                     : {y_reg[Y_W-1], y_reg} - (Y_W+1)'(THRESH);
    assign lvl_neg = lvl_v[Y_W];
    assign lvl_mag = lvl_neg ? (-lvl_v) : lvl_v;
    assign lvl_n   = lvl_mag[Y_W-1:LVL_PRE_SH];
    assign lvl_q   = lvl_prod_reg[LVL_PROD_W-1:LVL_RCP_SH];
    assign level   = lvl_neg_reg ? -LVL_W'(lvl_q) : LVL_W'(lvl_q);

    // result register frees up this cycle or is already empty
    assign rsp_load = (state_reg == ST_FIN) && (!rsp_valid_reg || !rsp_stall);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        acc_next       = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req_data.req_type == REQ_COEF)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next     = ST_MAC;
                        issue_cnt_next = '0;
                        acc_next       = {{(ACC_W-SMP_W-FRAC_SH){req_data.sample[SMP_W-1]}},
                                          req_data.sample, {FRAC_SH{1'b0}}};
                    end
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (s2_vld_reg)
                begin
                    acc_next = acc_reg - {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                end
                if (!issue && !s1_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            tap_count_reg <= TAPCFG_W'(TAP_RESET);
            coef_vld_reg  <= '0;
            dly_vld_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_vld_reg    <= issue;
            s2_vld_reg    <= s1_vld_reg;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (coef_we)
            begin
                coef_vld_reg[req_data.coef_index] <= 1'b1;
            end
            if (dly_we)
            begin
                dly_vld_reg[dly_waddr] <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        s1_idx_reg <= issue_cnt_reg[ADDR_W-1:0];
        cv_q_reg   <= coef_vld_reg[issue_cnt_reg[ADDR_W-1:0]];
        dv_q_reg   <= dly_vld_reg[issue_cnt_reg[ADDR_W-1:0]];
        prod_reg   <= coef_q * dly_q;
        if (req_xfer)
        begin
            is_smp_reg <= (req_data.req_type == REQ_SAMPLE);
        end
        if (state_reg == ST_RND)
        begin
            y_reg   <= y_sat;
            sat_reg <= y_clip;
        end
        if (state_reg == ST_DIV)
        begin
            lvl_prod_reg <= LVL_PROD_W'(lvl_n) * LVL_PROD_W'(LVL_RCP);
            lvl_neg_reg  <= lvl_neg;
        end
        if (rsp_load)
        begin
            rsp_reg.is_sample <= is_smp_reg;
            rsp_reg.filtered  <= is_smp_reg ? y_reg : '0;
            rsp_reg.level     <= is_smp_reg ? level : '0;
            rsp_reg.saturated <= is_smp_reg ? sat_reg : 1'b0;
        end
    end

    // checks
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (issue_cnt_reg <= taps))
        else $error("tap issue counter ran past the active tap count");

    a_mac_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg || s2_vld_reg) |-> (state_reg == ST_MAC))
        else $error("MAC pipeline busy outside the accumulate phase");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        shift_we |-> (dly_waddr != '0))
        else $error("delay shift wrote the newest-sample slot");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result appeared without a finish step");

endmodule

`default_nettype wire

/* design/apf_ram.sv */
`default_nettype none

module apf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the address being written returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
